@@ sv/pbd_pkg.sv @@
// Shared types, constants and lookup functions for the palette Bayer dither core.
`timescale 1ns / 1ps

package pbd_pkg;

    localparam int PIX_W       = 8;
    localparam int PIXELS      = 8;
    localparam int BLOCKS      = PIXELS / 2;
    localparam int LUMA_W      = 8;
    localparam int PAT_W       = 4;
    localparam int LUT_W       = PAT_W + LUMA_W;
    localparam int LUT_DEPTH   = 256;
    localparam int LUT_COPIES  = 2 * PIXELS;
    localparam int GAMMA_DEPTH = 256;

    typedef enum logic [1:0] {
        MODE_GAMMA   = 2'd0,
        MODE_PALETTE = 2'd1,
        MODE_ROW     = 2'd2,
        MODE_PAIR    = 2'd3
    } mode_t;

    typedef logic [LUT_COPIES-1:0][LUMA_W-1:0] luma_vec_t;
    typedef logic [BLOCKS-1:0][PAT_W-1:0]      pat_vec_t;

    typedef struct packed {
        logic             en;
        logic [7:0]       addr;
        logic [LUT_W-1:0] data;
    } lut_wr_t;

    function automatic logic [3:0] bayer(input logic [1:0] phase, input logic [1:0] col);
        logic [3:0] v;
        case ({phase, col})
            4'h0: v = 4'd0;   4'h1: v = 4'd8;   4'h2: v = 4'd2;   4'h3: v = 4'd10;
            4'h4: v = 4'd12;  4'h5: v = 4'd4;   4'h6: v = 4'd14;  4'h7: v = 4'd6;
            4'h8: v = 4'd3;   4'h9: v = 4'd11;  4'hA: v = 4'd1;   4'hB: v = 4'd9;
            4'hC: v = 4'd15;  4'hD: v = 4'd7;   4'hE: v = 4'd13;  4'hF: v = 4'd5;
            default: v = 4'd0;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] upper_pat(input logic [2:0] lv, input logic [1:0] vr);
        logic [1:0] p;
        case ({lv, vr})
            5'b001_00: p = 2'h2;  5'b001_01: p = 2'h1;
            5'b010_00: p = 2'h2;  5'b010_01: p = 2'h1;  5'b010_10: p = 2'h2;
            5'b011_00: p = 2'h1;  5'b011_01: p = 2'h2;
            5'b011_10: p = 2'h3;  5'b011_11: p = 2'h3;
            5'b100_00: p = 2'h3;
            default:   p = 2'h0;
        endcase
        return p;
    endfunction

    function automatic logic [1:0] lower_pat(input logic [2:0] lv, input logic [1:0] vr);
        logic [1:0] p;
        case ({lv, vr})
            5'b001_10: p = 2'h2;  5'b001_11: p = 2'h1;
            5'b010_00: p = 2'h1;  5'b010_01: p = 2'h2;
            5'b010_10: p = 2'h2;  5'b010_11: p = 2'h3;
            5'b011_00: p = 2'h3;  5'b011_01: p = 2'h3;
            5'b011_10: p = 2'h1;  5'b011_11: p = 2'h2;
            5'b100_00: p = 2'h3;
            default:   p = 2'h0;
        endcase
        return p;
    endfunction

endpackage

@@ sv/pbd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pbd_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/pbd_palette.sv @@
// Palette entry conversion: gamma-corrected luma to level, variant and 2x2 pattern.
`timescale 1ns / 1ps

module pbd_palette
    import pbd_pkg::*;
(
    input  logic          wr_valid,
    input  logic [7:0]    entry_index,
    input  logic [7:0]    gamma_q,
    output lut_wr_t       lut_wr
);

    logic [8:0] lv_sum;
    logic [2:0] lv;
    logic [1:0] vr;
    logic [1:0] pt;
    logic [1:0] pb;

    always_comb begin
        lv_sum = {1'b0, gamma_q} + 9'd32;
        lv     = lv_sum[8:6];
        if (lv == 3'd0 || lv == 3'd4) begin
            vr = 2'd0;
        end else begin
            vr = entry_index[5:4];
        end
        pt = upper_pat(lv, vr);
        pb = lower_pat(lv, vr);
        lut_wr.en   = wr_valid;
        lut_wr.addr = entry_index;
        lut_wr.data = {pb, pt, gamma_q};
    end

endmodule

@@ sv/pbd_dither.sv @@
// Threshold compare and 2x2 block pattern selection for one row or row pair.
`timescale 1ns / 1ps

module pbd_dither
    import pbd_pkg::*;
(
    input  luma_vec_t         luma,
    input  pat_vec_t          pattern,
    input  logic [BLOCKS-1:0] uniform,
    input  logic              pair_mode,
    input  logic [1:0]        phase,
    output logic [7:0]        top_byte,
    output logic [7:0]        bottom_byte
);

    logic [1:0]        lphase;
    logic [PIXELS-1:0] w_top;
    logic [PIXELS-1:0] w_bot;

    always_comb begin
        lphase = phase + 2'd1;
        for (int k = 0; k < PIXELS; k++) begin
            w_top[k] = luma[k] > {bayer(phase, 2'(k)), 4'b1000};
            w_bot[k] = luma[PIXELS + k] > {bayer(lphase, 2'(k)), 4'b1000};
        end
        for (int i = 0; i < BLOCKS; i++) begin
            if (pair_mode && uniform[i]) begin
                top_byte[7 - 2*i -: 2]    = pattern[i][1:0];
                bottom_byte[7 - 2*i -: 2] = pattern[i][3:2];
            end else begin
                top_byte[7 - 2*i -: 2]    = {w_top[2*i], w_top[2*i + 1]};
                bottom_byte[7 - 2*i -: 2] = {w_bot[2*i], w_bot[2*i + 1]};
            end
        end
        if (!pair_mode) begin
            bottom_byte = 8'd0;
        end
    end

endmodule

@@ sv/palette_bayer_dither_1bit_core.sv @@
// Top level of the palette to 1-bit LCD ordered dither core.
//
// One request channel (s_*) carries table writes and pixel rows; one result
// channel (m_*) carries LCD bytes, MSB leftmost, 1 meaning white.
// Mode 0 writes a gamma entry and mode 1 a palette entry; neither gives a
// result. Mode 2 dithers eight pixels into m_top_byte with m_bottom_byte zero.
// Mode 3 handles a row pair and returns both bytes.
// A result reaches the output register after passing the input register and
// the luma lookup register. One request is taken every cycle unless m_ready
// stalls the output; the rate is set by the sixteen luma lookup RAM copies,
// each with one read port, so that all sixteen pixels of a row pair are looked
// up in the same cycle.
// Palette writes update all copies as the entry leaves the input register, so a
// request following directly behind reads the new entry.
// Reset empties the pipeline and clears m_valid; table contents are undefined
// until written. When the receiver holds m_ready low the result stays in the
// output register, and requests are still taken until the stages behind it
// fill, after which s_ready drops.
`timescale 1ns / 1ps

module palette_bayer_dither_1bit_core
    import pbd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [7:0]  s_entry_index,
    input  logic [7:0]  s_gamma_value,
    input  logic [23:0] s_color_value,
    input  logic [63:0] s_row_pixels,
    input  logic [63:0] s_lower_row_pixels,
    input  logic [1:0]  s_row_phase,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_top_byte,
    output logic [7:0]  m_bottom_byte
);

    logic        v1_reg, v1_next;
    mode_t       mode1_reg;
    logic [7:0]  idx1_reg;
    logic [63:0] row1_reg;
    logic [63:0] lower1_reg;
    logic [1:0]  phase1_reg;

    logic              v2_reg, v2_next;
    logic              pair2_reg;
    logic [1:0]        phase2_reg;
    logic [BLOCKS-1:0] uni2_reg;
    logic [BLOCKS-1:0] uni_next;

    logic       m_valid_reg, m_valid_next;
    logic [7:0] top_reg;
    logic [7:0] bot_reg;

    logic        out_free;
    logic        adv2;
    logic        accept;
    logic        gamma_wr;
    logic [15:0] y_sum;
    logic [7:0]  gamma_q;
    lut_wr_t     lut_wr;

    logic [LUT_W-1:0] lut_q [LUT_COPIES];
    luma_vec_t        luma;
    pat_vec_t         pattern;
    logic [7:0]       top_byte;
    logic [7:0]       bottom_byte;

    assign out_free = !m_valid_reg || m_ready;
    assign adv2     = !v2_reg || out_free;
    assign s_ready  = !v1_reg || adv2;
    assign accept   = s_valid && s_ready;
    assign gamma_wr = accept && (s_mode == MODE_GAMMA);

    assign y_sum = 16'd77 * {8'd0, s_color_value[23:16]}
                 + 16'd151 * {8'd0, s_color_value[15:8]}
                 + 16'd28 * {8'd0, s_color_value[7:0]};

    pbd_ram #(
        .DATA_W (LUMA_W),
        .DEPTH  (GAMMA_DEPTH)
    ) u_gamma_ram (
        .aclk    (aclk),
        .wr_en   (gamma_wr),
        .wr_addr (s_entry_index),
        .wr_data (s_gamma_value),
        .rd_en   (s_ready),
        .rd_addr (y_sum[15:8]),
        .rd_data (gamma_q)
    );

    pbd_palette u_palette (
        .wr_valid    (v1_reg && (mode1_reg == MODE_PALETTE) && adv2),
        .entry_index (idx1_reg),
        .gamma_q     (gamma_q),
        .lut_wr      (lut_wr)
    );

    for (genvar k = 0; k < LUT_COPIES; k++) begin : g_lut
        logic [7:0] rd_addr;
        if (k < PIXELS) begin : g_top
            assign rd_addr = row1_reg[PIX_W*k +: PIX_W];
        end else begin : g_bot
            assign rd_addr = lower1_reg[PIX_W*(k - PIXELS) +: PIX_W];
        end
        pbd_ram #(
            .DATA_W (LUT_W),
            .DEPTH  (LUT_DEPTH)
        ) u_lut_ram (
            .aclk    (aclk),
            .wr_en   (lut_wr.en),
            .wr_addr (lut_wr.addr),
            .wr_data (lut_wr.data),
            .rd_en   (adv2),
            .rd_addr (rd_addr),
            .rd_data (lut_q[k])
        );
        assign luma[k] = lut_q[k][LUMA_W-1:0];
    end

    for (genvar i = 0; i < BLOCKS; i++) begin : g_pat
        assign pattern[i] = lut_q[2*i][LUT_W-1:LUMA_W];
    end

    always_comb begin
        for (int i = 0; i < BLOCKS; i++) begin
            uni_next[i] = row1_reg[PIX_W*2*i +: PIX_W] == row1_reg[PIX_W*(2*i+1) +: PIX_W]
                       && row1_reg[PIX_W*2*i +: PIX_W] == lower1_reg[PIX_W*2*i +: PIX_W]
                       && row1_reg[PIX_W*2*i +: PIX_W]
                          == lower1_reg[PIX_W*(2*i+1) +: PIX_W];
        end
        v1_next      = s_ready ? s_valid : v1_reg;
        v2_next      = adv2 ? (v1_reg && (mode1_reg == MODE_ROW || mode1_reg == MODE_PAIR))
                            : v2_reg;
        m_valid_next = out_free ? v2_reg : m_valid_reg;
    end

    pbd_dither u_dither (
        .luma        (luma),
        .pattern     (pattern),
        .uniform     (uni2_reg),
        .pair_mode   (pair2_reg),
        .phase       (phase2_reg),
        .top_byte    (top_byte),
        .bottom_byte (bottom_byte)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            mode1_reg  <= mode_t'(s_mode);
            idx1_reg   <= s_entry_index;
            row1_reg   <= s_row_pixels;
            lower1_reg <= s_lower_row_pixels;
            phase1_reg <= s_row_phase;
        end
        if (adv2) begin
            pair2_reg  <= (mode1_reg == MODE_PAIR);
            phase2_reg <= phase1_reg;
            uni2_reg   <= uni_next;
        end
        if (out_free) begin
            top_reg <= top_byte;
            bot_reg <= bottom_byte;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_top_byte    = top_reg;
    assign m_bottom_byte = bot_reg;

    a_result_from_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(v2_reg))
        else $error("Result appeared without a lookup stage request.");

    a_palette_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        lut_wr.en |=> !v2_reg)
        else $error("Palette write produced a result request.");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("Input stalled while the output register is empty.");

endmodule
